// ===== rtl/jcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// jcmf_pkg
// Shared types and constants for the channel message framer: byte codes,
// parse phases, result kinds, drop codes and the result record.
// ----------------------------------------------------------------------------
package jcmf_pkg;

  // Width of the group nesting counter
  localparam int DEPTH_BITS = 16;

  localparam int ID_WIDTH = 64;

  // Result kinds
  localparam logic [1:0] KIND_BODY = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Drop codes
  localparam logic [2:0] ERR_NO_OPEN  = 3'd0;
  localparam logic [2:0] ERR_NO_NUM   = 3'd1;
  localparam logic [2:0] ERR_NO_COMMA = 3'd2;
  localparam logic [2:0] ERR_NO_CLOSE = 3'd3;
  localparam logic [2:0] ERR_TOO_DEEP = 3'd4;

  // Byte codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Magnitude limits for the id
  localparam logic [ID_WIDTH-1:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [ID_WIDTH-1:0] MAG_TENTH = 64'd922337203685477580;
  localparam logic [ID_WIDTH-1:0] ID_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_PRE_NUM    = 4'd1,
    PH_SIGN       = 4'd2,
    PH_NUM        = 4'd3,
    PH_AFTER_NUM  = 4'd4,
    PH_PRE_BODY   = 4'd5,
    PH_STR        = 4'd6,
    PH_GROUP      = 4'd7,
    PH_SCALAR     = 4'd8,
    PH_AFTER_BODY = 4'd9
  } phase_t;

  typedef struct packed {
    logic                       emit;
    logic [1:0]                 kind;
    logic [7:0]                 body_byte;
    logic signed [ID_WIDTH-1:0] message_id;
    logic [2:0]                 error_code;
  } result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// ===== rtl/jcmf_byte_if.sv =====
// ----------------------------------------------------------------------------
// jcmf_byte_if
// Byte stream channel: valid/ready handshake with one byte per request.
// ----------------------------------------------------------------------------
interface jcmf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== rtl/jcmf_result_if.sv =====
// ----------------------------------------------------------------------------
// jcmf_result_if
// Result channel: valid/ready handshake carrying one framer result per request.
// ----------------------------------------------------------------------------
interface jcmf_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         body_byte;
  logic signed [63:0] message_id;
  logic [2:0]         error_code;

  modport source (
    output valid, output kind, output body_byte, output message_id,
    output error_code, input ready
  );
  modport sink (
    input valid, input kind, input body_byte, input message_id,
    input error_code, output ready
  );
endinterface

// ===== rtl/jcmf_in_reg.sv =====
// ----------------------------------------------------------------------------
// jcmf_in_reg
// Input register: captures one byte request and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module jcmf_in_reg (
  input  logic       clk,
  input  logic       rst,
  jcmf_byte_if.sink  stream,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // Take a new request when empty or when the held byte moves on
  assign stream.ready = !held_valid || advance;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (stream.ready) begin
      held_valid <= stream.valid;
    end
  end

  // Capture byte
  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      held_byte <= stream.in_byte;
    end
  end

endmodule

// ===== rtl/jcmf_parse.sv =====
// ----------------------------------------------------------------------------
// jcmf_parse
// Parse state machine: holds phase, id accumulator and group tracking, and
// turns each byte into at most one result in a single step.
// ----------------------------------------------------------------------------
module jcmf_parse import jcmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] b,
  output result_t    res
);

  phase_t                phase, phase_next;
  logic [ID_WIDTH-1:0]   acc, acc_next;
  logic                  neg, neg_next;
  logic [DEPTH_BITS-1:0] depth, depth_next;
  logic                  in_str, in_str_next;
  logic                  esc, esc_next;

  logic                  blank, digit, open_b, close_b;
  logic [ID_WIDTH-1:0]   acc_ten, acc_dig, done_id;
  logic [DEPTH_BITS-1:0] depth_dec;
  logic                  finish;

  assign blank   = is_blank(b);
  assign digit   = is_digit(b);
  assign open_b  = (b == CH_LBRACK) || (b == CH_LBRACE);
  assign close_b = (b == CH_RBRACK) || (b == CH_RBRACE);

  // Accumulate one decimal digit with saturation at the magnitude limit
  assign acc_ten = (acc << 3) + (acc << 1) + {{(ID_WIDTH-4){1'b0}}, b[3:0] - CH_ZERO[3:0]};
  assign acc_dig = ((acc > MAG_TENTH) || (acc_ten > MAG_LIMIT)) ? MAG_LIMIT : acc_ten;

  // Signed id on completion
  assign done_id = neg ? (~acc + {{(ID_WIDTH-1){1'b0}}, 1'b1})
                       : (acc[ID_WIDTH-1] ? ID_MAX : acc);

  assign depth_dec = depth - {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  // Result decode
  always_comb begin
    res            = '0;
    res.body_byte  = '0;
    unique case (phase)
      PH_IDLE: begin
        if (!blank && (b != CH_LBRACK)) begin
          res.emit = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_NO_OPEN;
        end
      end
      PH_PRE_NUM: begin
        if (!blank && (b != CH_MINUS) && (b != CH_PLUS) && !digit) begin
          res.emit = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_NO_NUM;
        end
      end
      PH_SIGN, PH_NUM: begin
        if (!digit && !blank && (b != CH_COMMA)) begin
          res.emit = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_NO_COMMA;
        end
      end
      PH_AFTER_NUM: begin
        if (!blank && (b != CH_COMMA)) begin
          res.emit = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_NO_COMMA;
        end
      end
      PH_PRE_BODY, PH_SCALAR: begin
        if (blank) begin
          res.emit = 1'b0;
        end else if (b == CH_RBRACK) begin
          res.emit = 1'b1; res.kind = KIND_DONE; res.message_id = done_id;
        end else if ((b == CH_COMMA) || (b == CH_RBRACE)) begin
          res.emit = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_NO_CLOSE;
        end else begin
          res.emit = 1'b1; res.kind = KIND_BODY; res.body_byte = b;
        end
      end
      PH_STR: begin
        res.emit = 1'b1; res.kind = KIND_BODY; res.body_byte = b;
      end
      PH_GROUP: begin
        if (!in_str && open_b && (depth == {DEPTH_BITS{1'b1}})) begin
          res.emit = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_TOO_DEEP;
        end else begin
          res.emit = 1'b1; res.kind = KIND_BODY; res.body_byte = b;
        end
      end
      PH_AFTER_BODY: begin
        if (blank) begin
          res.emit = 1'b0;
        end else if (b == CH_RBRACK) begin
          res.emit = 1'b1; res.kind = KIND_DONE; res.message_id = done_id;
        end else begin
          res.emit = 1'b1; res.kind = KIND_DROP; res.error_code = ERR_NO_CLOSE;
        end
      end
      default: res = '0;
    endcase
  end

  // A drop or a completion returns everything to idle
  assign finish = res.emit && (res.kind != KIND_BODY);

  // Next state
  always_comb begin
    phase_next  = phase;
    acc_next    = acc;
    neg_next    = neg;
    depth_next  = depth;
    in_str_next = in_str;
    esc_next    = esc;
    if (finish) begin
      phase_next  = PH_IDLE;
      acc_next    = '0;
      neg_next    = 1'b0;
      depth_next  = '0;
      in_str_next = 1'b0;
      esc_next    = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (b == CH_LBRACK) phase_next = PH_PRE_NUM;
        end
        PH_PRE_NUM: begin
          if ((b == CH_MINUS) || (b == CH_PLUS)) begin
            neg_next   = (b == CH_MINUS);
            phase_next = PH_SIGN;
          end else if (digit) begin
            acc_next   = acc_dig;
            phase_next = PH_NUM;
          end
        end
        PH_SIGN, PH_NUM: begin
          if (digit) begin
            acc_next   = acc_dig;
            phase_next = PH_NUM;
          end else if (blank) begin
            phase_next = PH_AFTER_NUM;
          end else if (b == CH_COMMA) begin
            phase_next = PH_PRE_BODY;
          end
        end
        PH_AFTER_NUM: begin
          if (b == CH_COMMA) phase_next = PH_PRE_BODY;
        end
        PH_PRE_BODY: begin
          if (blank) begin
            phase_next = PH_PRE_BODY;
          end else if (b == CH_QUOTE) begin
            phase_next = PH_STR;
          end else if (open_b) begin
            depth_next  = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
            in_str_next = 1'b0;
            esc_next    = 1'b0;
            phase_next  = PH_GROUP;
          end else begin
            phase_next = PH_SCALAR;
          end
        end
        PH_STR: begin
          if (esc) begin
            esc_next = 1'b0;
          end else if (b == CH_BSLASH) begin
            esc_next = 1'b1;
          end else if (b == CH_QUOTE) begin
            phase_next = PH_AFTER_BODY;
          end
        end
        PH_GROUP: begin
          if (in_str) begin
            if (esc) begin
              esc_next = 1'b0;
            end else if (b == CH_BSLASH) begin
              esc_next = 1'b1;
            end else if (b == CH_QUOTE) begin
              in_str_next = 1'b0;
            end
          end else if (b == CH_QUOTE) begin
            in_str_next = 1'b1;
          end else if (open_b) begin
            depth_next = depth + {{(DEPTH_BITS-1){1'b0}}, 1'b1};
          end else if (close_b) begin
            depth_next = depth_dec;
            if (depth_dec == '0) phase_next = PH_AFTER_BODY;
          end
        end
        PH_SCALAR: begin
          if (blank) phase_next = PH_AFTER_BODY;
        end
        PH_AFTER_BODY: begin
          phase_next = PH_AFTER_BODY;
        end
        default: begin
          phase_next  = PH_IDLE;
          acc_next    = '0;
          neg_next    = 1'b0;
          depth_next  = '0;
          in_str_next = 1'b0;
          esc_next    = 1'b0;
        end
      endcase
    end
  end

  // Advance state once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      acc    <= '0;
      neg    <= 1'b0;
      depth  <= '0;
      in_str <= 1'b0;
      esc    <= 1'b0;
    end else if (step) begin
      phase  <= phase_next;
      acc    <= acc_next;
      neg    <= neg_next;
      depth  <= depth_next;
      in_str <= in_str_next;
      esc    <= esc_next;
    end
  end

endmodule

// ===== rtl/jcmf_out_reg.sv =====
// ----------------------------------------------------------------------------
// jcmf_out_reg
// Result register: holds one result until the sink takes the request.
// ----------------------------------------------------------------------------
module jcmf_out_reg import jcmf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  result_t       res,
  output logic          can_load,
  jcmf_result_if.source result
);

  assign can_load = !result.valid || result.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (can_load) begin
      result.valid <= load;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result.kind       <= res.kind;
      result.body_byte  <= res.body_byte;
      result.message_id <= res.message_id;
      result.error_code <= res.error_code;
    end
  end

endmodule

// ===== rtl/json_channel_message_framer_unit.sv =====
// Path: an accepted byte waits in the input register, is decoded by the parse
//   step and is loaded into the result register once that register has room.
// Throughput: one byte per cycle; the input register, the parse step and the
//   result register each pass one item a cycle while the sink keeps up.
// Bytes that give no result (blanks, id digits, punctuation) still pass the parse step.
// Reset: synchronous rst clears both registers' valid flags and returns the
//   parser to idle, awaiting an open bracket.
// ----------------------------------------------------------------------------
// json_channel_message_framer_unit
// Frames [number, value] messages from a byte stream: body bytes stream out,
// the closing bracket emits the id, and malformed bytes emit a drop code.
// ----------------------------------------------------------------------------
module json_channel_message_framer_unit import jcmf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  jcmf_byte_if.sink     stream,
  jcmf_result_if.source result
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       can_load;
  logic       advance;
  result_t    res;

  // Move the held byte on when the result register has room
  assign advance = held_valid && can_load;

  jcmf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  jcmf_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .b    (held_byte),
    .res  (res)
  );

  jcmf_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res.emit),
    .res      (res),
    .can_load (can_load),
    .result   (result)
  );

endmodule

// ===== rtl/jcmf_checker.sv =====
// ----------------------------------------------------------------------------
// jcmf_checker
// Port-level checks for the framer: result field consistency, stall hold and
// input availability when the result register is empty.
// ----------------------------------------------------------------------------
module jcmf_checker import jcmf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [7:0]         body_byte,
  input logic signed [63:0] message_id,
  input logic [2:0]         error_code
);

  // Only defined kinds leave the block
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_BODY) || (kind == KIND_DONE) || (kind == KIND_DROP))
    else $error("undefined result kind");

  // Unused fields stay zero for each kind
  a_fields_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((kind == KIND_BODY) && (message_id == 0) && (error_code == 0)) ||
      ((kind == KIND_DONE) && (body_byte == 0) && (error_code == 0)) ||
      ((kind == KIND_DROP) && (body_byte == 0) && (message_id == 0) &&
       (error_code <= ERR_TOO_DEEP)))
    else $error("result fields inconsistent with kind");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(body_byte) &&
      $stable(message_id) && $stable(error_code))
    else $error("stalled result changed");

  // With the result register empty the input is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while result register empty");

endmodule

bind json_channel_message_framer_unit jcmf_checker u_jcmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (stream.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .kind       (result.kind),
  .body_byte  (result.body_byte),
  .message_id (result.message_id),
  .error_code (result.error_code)
);
